// ===== rtl/core/fpa_pkg.sv =====
package fpa_pkg;

  localparam int DIV_BITS = 32;

  localparam logic [3:0] OP_ADD = 4'd0;
  localparam logic [3:0] OP_SUB = 4'd1;
  localparam logic [3:0] OP_MUL = 4'd2;
  localparam logic [3:0] OP_DIV = 4'd3;
  localparam logic [3:0] OP_MIN = 4'd4;
  localparam logic [3:0] OP_MAX = 4'd5;
  localparam logic [3:0] OP_INC = 4'd6;
  localparam logic [3:0] OP_DEC = 4'd7;
  localparam logic [3:0] OP_INT = 4'd8;

  localparam logic [1:0] KIND_SIMPLE = 2'd0;
  localparam logic [1:0] KIND_MUL = 2'd1;
  localparam logic [1:0] KIND_DIV = 2'd2;

  localparam logic [31:0] SAT_POS = 32'h7fff_ffff;
  localparam logic [31:0] SAT_NEG = 32'h8000_0000;
  localparam logic [63:0] LIM_POS = 64'h0000_0000_7fff_ffff;
  localparam logic [63:0] LIM_NEG = 64'h0000_0000_8000_0000;

  typedef struct packed {
    logic [3:0] operation;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] result_raw;
    logic a_less;
    logic a_greater;
    logic a_equal;
    logic divide_by_zero;
    logic saturated;
  } out_word_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [31:0] res;
    logic a_less;
    logic a_greater;
    logic a_equal;
    logic dz;
    logic neg;
    logic [31:0] mag_a;
    logic [31:0] mag_b;
  } cls_t;

endpackage

// ===== rtl/core/fpa_front.sv =====
module fpa_front #(
  parameter int FRAC_BITS = 8
) (
  input  logic             push,
  input  logic             q_full,
  input  fpa_pkg::in_word_t in_word,
  output logic             wr_en,
  output fpa_pkg::cls_t    cls
);
  import fpa_pkg::*;

  logic signed [31:0] a;
  logic signed [31:0] b;
  logic [31:0] ua;
  logic [31:0] ub;

  assign a = in_word.operand_a;
  assign b = in_word.operand_b;
  assign ua = in_word.operand_a;
  assign ub = in_word.operand_b;
  assign wr_en = push && !q_full;

  always_comb begin
    cls = '0;
    cls.kind = KIND_SIMPLE;
    cls.a_less = a < b;
    cls.a_greater = a > b;
    cls.a_equal = a == b;
    cls.neg = ua[31] ^ ub[31];
    cls.mag_a = ua[31] ? (~ua + 32'd1) : ua;
    cls.mag_b = ub[31] ? (~ub + 32'd1) : ub;
    case (in_word.operation)
      OP_ADD: cls.res = ua + ub;
      OP_SUB: cls.res = ua - ub;
      OP_MUL: cls.kind = KIND_MUL;
      OP_DIV: begin
        if (ub == 32'd0) begin
          cls.dz = 1'b1;
        end else begin
          cls.kind = KIND_DIV;
        end
      end
      OP_MIN: cls.res = (a < b) ? ua : ub;
      OP_MAX: cls.res = (a > b) ? ua : ub;
      OP_INC: cls.res = ua + 32'd1;
      OP_DEC: cls.res = ua - 32'd1;
      OP_INT: cls.res = 32'(a >>> FRAC_BITS);
      default: cls.res = 32'd0;
    endcase
  end

endmodule

// ===== rtl/core/fpa_queue.sv =====
module fpa_queue #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  fpa_pkg::cls_t wr_data,
  output logic          full,
  input  logic          rd_en,
  output fpa_pkg::cls_t rd_data,
  output logic          empty
);
  import fpa_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cls_t mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r;
  logic [AW-1:0] wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r;
  logic [AW-1:0] rd_ptr_nxt;
  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;

  assign full = count_r == CW'(DEPTH);
  assign empty = count_r == '0;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt = count_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (wr_en && !rd_en) begin
      count_nxt = count_r + 1'b1;
    end else if (rd_en && !wr_en) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// ===== rtl/core/fpa_back.sv =====
module fpa_back #(
  parameter int FRAC_BITS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  fpa_pkg::cls_t      q_data,
  output logic               q_rd,
  input  logic               pop,
  output logic               empty,
  output fpa_pkg::out_word_t out_word
);
  import fpa_pkg::*;

  localparam logic [63:0] HALF = 64'd1 << (FRAC_BITS - 1);

  logic adv;

  logic [DIV_BITS:0] dv_valid_r;
  cls_t              dv_cls_r [DIV_BITS+1];
  logic [31:0]       dv_rem_r [DIV_BITS+1];
  logic [31:0]       dv_q_r [DIV_BITS+1];
  logic [DIV_BITS:0] dv_ovf_r;

  logic [31:0] rem0;

  logic        m_valid_r;
  cls_t        m_cls_r;
  logic [63:0] m_prod_r;
  logic [32:0] m_qr_r;
  logic        m_ovf_r;
  logic        m_rnd;

  logic        r_valid_r;
  cls_t        r_cls_r;
  logic [63:0] r_mag_r;
  logic [63:0] r_mag_nxt;

  logic        out_valid_r;
  out_word_t   out_word_r;
  out_word_t   out_word_nxt;

  assign adv = !out_valid_r || pop;
  assign q_rd = adv && !q_empty;
  assign empty = !out_valid_r;
  assign out_word = out_word_r;

  assign rem0 = {{(32 - FRAC_BITS){1'b0}}, q_data.mag_a[31:32-FRAC_BITS]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_valid_r[0] <= 1'b0;
    end else if (adv) begin
      dv_valid_r[0] <= q_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_cls_r[0] <= q_data;
      dv_rem_r[0] <= rem0;
      dv_q_r[0] <= '0;
      dv_ovf_r[0] <= rem0 >= q_data.mag_b;
    end
  end

  for (genvar i = 1; i <= DIV_BITS; i++) begin : g_div
    localparam int BIT_IDX = DIV_BITS - i;
    logic        nb;
    logic [32:0] trial;
    logic        ge;
    logic [32:0] diff;

    if (BIT_IDX >= FRAC_BITS) begin : g_bit
      assign nb = dv_cls_r[i-1].mag_a[BIT_IDX - FRAC_BITS];
    end else begin : g_zero
      assign nb = 1'b0;
    end

    assign trial = {dv_rem_r[i-1], nb};
    assign ge = trial >= {1'b0, dv_cls_r[i-1].mag_b};
    assign diff = trial - {1'b0, dv_cls_r[i-1].mag_b};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_valid_r[i] <= 1'b0;
      end else if (adv) begin
        dv_valid_r[i] <= dv_valid_r[i-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_cls_r[i] <= dv_cls_r[i-1];
        dv_rem_r[i] <= ge ? diff[31:0] : trial[31:0];
        dv_q_r[i] <= {dv_q_r[i-1][30:0], ge};
        dv_ovf_r[i] <= dv_ovf_r[i-1];
      end
    end
  end

  assign m_rnd = {dv_rem_r[DIV_BITS], 1'b0} >= {1'b0, dv_cls_r[DIV_BITS].mag_b};

  always_comb begin
    if (m_cls_r.kind == KIND_MUL) begin
      r_mag_nxt = (m_prod_r + HALF) >> FRAC_BITS;
    end else if (m_ovf_r) begin
      r_mag_nxt = '1;
    end else begin
      r_mag_nxt = {31'd0, m_qr_r};
    end
  end

  always_comb begin
    out_word_nxt.a_less = r_cls_r.a_less;
    out_word_nxt.a_greater = r_cls_r.a_greater;
    out_word_nxt.a_equal = r_cls_r.a_equal;
    out_word_nxt.divide_by_zero = r_cls_r.dz;
    out_word_nxt.saturated = 1'b0;
    out_word_nxt.result_raw = r_cls_r.res;
    if (r_cls_r.kind != KIND_SIMPLE) begin
      if (r_cls_r.neg) begin
        if (r_mag_r > LIM_NEG) begin
          out_word_nxt.saturated = 1'b1;
          out_word_nxt.result_raw = SAT_NEG;
        end else begin
          out_word_nxt.result_raw = ~r_mag_r[31:0] + 32'd1;
        end
      end else begin
        if (r_mag_r > LIM_POS) begin
          out_word_nxt.saturated = 1'b1;
          out_word_nxt.result_raw = SAT_POS;
        end else begin
          out_word_nxt.result_raw = r_mag_r[31:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_valid_r <= 1'b0;
      r_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      m_valid_r <= dv_valid_r[DIV_BITS];
      r_valid_r <= m_valid_r;
      out_valid_r <= r_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_cls_r <= dv_cls_r[DIV_BITS];
      m_prod_r <= dv_cls_r[DIV_BITS].mag_a * dv_cls_r[DIV_BITS].mag_b;
      m_qr_r <= {1'b0, dv_q_r[DIV_BITS]} + {32'd0, m_rnd};
      m_ovf_r <= dv_ovf_r[DIV_BITS];
      r_cls_r <= m_cls_r;
      r_mag_r <= r_mag_nxt;
      out_word_r <= out_word_nxt;
    end
  end

endmodule

// ===== rtl/core/fixed_point_q24_8_alu.sv =====
// Signed fixed-point ALU for 32-bit raw values with FRAC_BITS fraction bits.
// The input side is a queue: a word of operation, operand_a and operand_b is
// taken at each rising edge where push is high and full is low.
// The result side is a queue too: while empty is low, out_word holds the
// oldest result, and it is taken at each rising edge where pop is high.
// Every operation follows the same path, so results leave in input order.
// One word per cycle is sustained while the result side does not stall.
// The back pipeline is an input register, then the 32-stage restoring
// divider, one quotient bit per stage, followed by a multiply stage, a
// rounding stage and the clamp that loads the output register.
// While the output register holds an untaken result, the whole back pipeline
// holds; the front queue of QUEUE_DEPTH words keeps taking input until it
// fills, and full then stays high until pop frees the output register.
// Synchronous reset empties the queue and clears every valid bit.
module fixed_point_q24_8_alu #(
  parameter int FRAC_BITS = 8,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  fpa_pkg::in_word_t  in_word,
  output logic               empty,
  input  logic               pop,
  output fpa_pkg::out_word_t out_word
);
  import fpa_pkg::*;

  logic q_wr;
  logic q_rd;
  logic q_empty;
  cls_t wr_cls;
  cls_t rd_cls;

  fpa_front #(
    .FRAC_BITS(FRAC_BITS)
  ) u_front (
    .push   (push),
    .q_full (full),
    .in_word(in_word),
    .wr_en  (q_wr),
    .cls    (wr_cls)
  );

  fpa_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (q_wr),
    .wr_data(wr_cls),
    .full   (full),
    .rd_en  (q_rd),
    .rd_data(rd_cls),
    .empty  (q_empty)
  );

  fpa_back #(
    .FRAC_BITS(FRAC_BITS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_data  (rd_cls),
    .q_rd    (q_rd),
    .pop     (pop),
    .empty   (empty),
    .out_word(out_word)
  );

  a_one_compare: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> $onehot({out_word.a_less, out_word.a_greater, out_word.a_equal}))
    else $error("compare flags not exclusive");

  a_flag_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> !(out_word.divide_by_zero && out_word.saturated))
    else $error("divide by zero and saturation together");

  a_queue_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (q_wr && q_empty) |=> !q_empty)
    else $error("accepted word lost in queue");

endmodule

// ===== tb/tb_fixed_point_q24_8_alu.sv =====
module tb_fixed_point_q24_8_alu;
  timeunit 1ns;
  timeprecision 1ps;

  import fpa_pkg::*;

  localparam int FRAC_BITS = 8;
  localparam int RANDOM_WORDS = 1950;
  localparam int NUM_DIRECTED = 25;
  localparam int LONG_HOLD = 300;
  localparam int DRAIN_CYCLES = 60;
  localparam int CYCLE_LIMIT = 400000;

  localparam logic [3:0] OP_FIRST_UNUSED = 4'd9;
  localparam logic [3:0] OP_LAST_CODE = 4'd15;

  localparam logic [4:0] F_NONE = 5'b00000;
  localparam logic [4:0] F_LT = 5'b10000;
  localparam logic [4:0] F_GT = 5'b01000;
  localparam logic [4:0] F_EQ = 5'b00100;
  localparam logic [4:0] F_DZ = 5'b00010;
  localparam logic [4:0] F_SAT = 5'b00001;

  typedef struct {
    logic [3:0] op;
    logic [31:0] a;
    logic [31:0] b;
    bit pinned;
    out_word_t want;
  } directed_row_t;

  typedef struct {
    bit pinned;
    out_word_t want;
  } pending_t;

  logic clk = 1'b0;
  logic rst_n;
  logic push;
  logic full;
  in_word_t in_word;
  logic empty;
  logic pop;
  out_word_t out_word;

  pending_t pending_words[$];
  out_word_t expected_results[$];

  int error_count = 0;
  int burst_left = 0;
  int words_accepted = 0;
  int results_checked = 0;
  int mul_words = 0;
  int div_words = 0;
  int unused_words = 0;
  int zero_div_results = 0;
  int clamped_results = 0;
  int full_run = 0;
  int longest_full_stall = 0;
  bit long_hold_done = 1'b0;

  // Rows with pinned set carry a result read straight off the spec; the rest
  // go through the predictor.
  directed_row_t directed_rows [NUM_DIRECTED] = '{
    '{OP_ADD, 32'h7fff_ffff, 32'h0000_0001, 1'b1, {32'h8000_0000, F_GT}},
    '{OP_SUB, 32'h8000_0000, 32'h0000_0001, 1'b1, {32'h7fff_ffff, F_LT}},
    '{OP_SUB, 32'h0000_0000, 32'h8000_0000, 1'b1, {32'h8000_0000, F_GT}},
    '{OP_MUL, 32'h7fff_ffff, 32'h7fff_ffff, 1'b1, {32'h7fff_ffff, F_EQ | F_SAT}},
    '{OP_MUL, 32'h8000_0000, 32'h7fff_ffff, 1'b1, {32'h8000_0000, F_LT | F_SAT}},
    '{OP_MUL, 32'h8000_0000, 32'h8000_0000, 1'b1, {32'h7fff_ffff, F_EQ | F_SAT}},
    '{OP_MUL, 32'h8000_0000, 32'h0000_0100, 1'b0, '0},
    '{OP_MUL, 32'h0000_0001, 32'h0000_0080, 1'b0, '0},
    '{OP_MUL, 32'hffff_ffff, 32'h0000_0080, 1'b0, '0},
    '{OP_MUL, 32'h0000_0180, 32'hffff_fd00, 1'b0, '0},
    '{OP_DIV, 32'h0000_0500, 32'h0000_0000, 1'b1, {32'h0000_0000, F_GT | F_DZ}},
    '{OP_DIV, 32'h0000_0000, 32'h0000_0000, 1'b1, {32'h0000_0000, F_EQ | F_DZ}},
    '{OP_DIV, 32'h7fff_ffff, 32'h0000_0001, 1'b1, {32'h7fff_ffff, F_GT | F_SAT}},
    '{OP_DIV, 32'h8000_0000, 32'h0000_0001, 1'b1, {32'h8000_0000, F_LT | F_SAT}},
    '{OP_DIV, 32'h8000_0000, 32'hffff_ffff, 1'b1, {32'h7fff_ffff, F_LT | F_SAT}},
    '{OP_DIV, 32'h0000_0100, 32'h0000_0300, 1'b0, '0},
    '{OP_DIV, 32'hffff_ff00, 32'h0000_0300, 1'b0, '0},
    '{OP_MIN, 32'h7fff_ffff, 32'h8000_0000, 1'b1, {32'h8000_0000, F_GT}},
    '{OP_MAX, 32'h7fff_ffff, 32'h8000_0000, 1'b1, {32'h7fff_ffff, F_GT}},
    '{OP_INC, 32'h7fff_ffff, 32'h0000_0000, 1'b1, {32'h8000_0000, F_GT}},
    '{OP_DEC, 32'h8000_0000, 32'h0000_0000, 1'b1, {32'h7fff_ffff, F_LT}},
    '{OP_INT, 32'hffff_ffff, 32'h0000_0000, 1'b1, {32'hffff_ffff, F_LT}},
    '{OP_INT, 32'h7fff_ffff, 32'h7fff_ffff, 1'b1, {32'h007f_ffff, F_EQ}},
    '{OP_FIRST_UNUSED, 32'h0000_0001, 32'h0000_0002, 1'b1, {32'h0000_0000, F_LT}},
    '{OP_LAST_CODE, 32'h8000_0000, 32'h7fff_ffff, 1'b1, {32'h0000_0000, F_LT}}
  };

  fixed_point_q24_8_alu #(
    .FRAC_BITS(FRAC_BITS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .push(push),
    .full(full),
    .in_word(in_word),
    .empty(empty),
    .pop(pop),
    .out_word(out_word)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [31:0] clamp_round(input logic [63:0] mag, input logic neg,
                                              output logic sat);
    logic [63:0] negated;
    sat = 1'b0;
    negated = 64'd0 - mag;
    if (neg) begin
      if (mag > LIM_NEG) begin
        sat = 1'b1;
        return SAT_NEG;
      end
      return negated[31:0];
    end
    if (mag > LIM_POS) begin
      sat = 1'b1;
      return SAT_POS;
    end
    return mag[31:0];
  endfunction

  function automatic out_word_t alu_predict(input in_word_t w);
    out_word_t r;
    logic signed [63:0] sa;
    logic signed [63:0] sb;
    logic signed [63:0] prod;
    logic [63:0] mag_a;
    logic [63:0] mag_b;
    logic [63:0] mag;
    logic sat;
    r = '0;
    sat = 1'b0;
    sa = $signed(w.operand_a);
    sb = $signed(w.operand_b);
    mag_a = (sa < 0) ? -sa : sa;
    mag_b = (sb < 0) ? -sb : sb;
    r.a_less = sa < sb;
    r.a_greater = sa > sb;
    r.a_equal = sa == sb;
    case (w.operation)
      OP_ADD: r.result_raw = w.operand_a + w.operand_b;
      OP_SUB: r.result_raw = w.operand_a - w.operand_b;
      OP_MUL: begin
        prod = sa * sb;
        mag = (prod < 0) ? -prod : prod;
        mag = (mag + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        r.result_raw = clamp_round(mag, prod < 0, sat);
      end
      OP_DIV: begin
        if (sb == 0) begin
          r.divide_by_zero = 1'b1;
        end else begin
          mag = ((mag_a << (FRAC_BITS + 1)) + mag_b) / (mag_b << 1);
          r.result_raw = clamp_round(mag, (sa < 0) != (sb < 0), sat);
        end
      end
      OP_MIN: r.result_raw = (sa < sb) ? w.operand_a : w.operand_b;
      OP_MAX: r.result_raw = (sa > sb) ? w.operand_a : w.operand_b;
      OP_INC: r.result_raw = w.operand_a + 32'd1;
      OP_DEC: r.result_raw = w.operand_a - 32'd1;
      OP_INT: r.result_raw = $signed(w.operand_a) >>> FRAC_BITS;
      default: r.result_raw = '0;
    endcase
    r.saturated = sat;
    return r;
  endfunction

  function automatic logic [31:0] pick_operand();
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = $urandom;
      4, 5, 6: v = $urandom_range(0, 8192) - 4096;
      7: begin
        case ($urandom_range(0, 4))
          0: v = SAT_POS;
          1: v = SAT_NEG;
          2: v = '0;
          3: v = '1;
          default: v = 32'd1;
        endcase
      end
      8: v = $urandom & 32'h000f_ffff;
      default: v = $urandom >> $urandom_range(0, 31);
    endcase
    if ($urandom_range(0, 3) == 0) v = -v;
    return v;
  endfunction

  function automatic in_word_t random_word();
    in_word_t w;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 4) begin
      w.operation = 4'($urandom_range(OP_FIRST_UNUSED, OP_LAST_CODE));
    end else if (pick < 30) begin
      w.operation = ($urandom_range(0, 1) == 0) ? OP_MUL : OP_DIV;
    end else begin
      w.operation = 4'($urandom_range(OP_ADD, OP_INT));
    end
    w.operand_a = pick_operand();
    w.operand_b = pick_operand();
    if ($urandom_range(0, 15) == 0) w.operand_b = w.operand_a;
    if (w.operation == OP_DIV && $urandom_range(0, 11) == 0) w.operand_b = '0;
    return w;
  endfunction

  task automatic offer(input in_word_t w, input bit pinned, input out_word_t want);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    pending_words.push_back('{pinned, want});
    push <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (full) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      error_count++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : scoreboard
    pending_t info;
    out_word_t want;
    if (rst_n) begin
      if (push && full) full_run++;
      else full_run = 0;
      if (full_run > longest_full_stall) longest_full_stall = full_run;

      if (push && !full) begin
        if (pending_words.size() != 0) info = pending_words.pop_front();
        else info = '{1'b0, '0};
        expected_results.push_back(info.pinned ? info.want : alu_predict(in_word));
        words_accepted++;
        if (in_word.operation == OP_MUL) mul_words++;
        if (in_word.operation == OP_DIV) div_words++;
        if (in_word.operation > OP_INT) unused_words++;
      end

      if (pop && !empty) begin
        if (expected_results.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result word, expected none, got %h", $time, out_word);
        end else begin
          want = expected_results.pop_front();
          check_field("result_raw", want.result_raw, out_word.result_raw);
          check_field("a_less", 32'(want.a_less), 32'(out_word.a_less));
          check_field("a_greater", 32'(want.a_greater), 32'(out_word.a_greater));
          check_field("a_equal", 32'(want.a_equal), 32'(out_word.a_equal));
          check_field("divide_by_zero", 32'(want.divide_by_zero),
                      32'(out_word.divide_by_zero));
          check_field("saturated", 32'(want.saturated), 32'(out_word.saturated));
          results_checked++;
          if (want.divide_by_zero) zero_div_results++;
          if (want.saturated) clamped_results++;
        end
      end
    end
  end

  initial begin : receiver
    int seg_left;
    int mode;
    int phase;
    int hold_left;
    logic pop_next;
    pop = 1'b0;
    seg_left = 0;
    mode = 0;
    phase = 0;
    hold_left = 0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (!long_hold_done && results_checked >= 200) begin
        long_hold_done = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (seg_left == 0) begin
        seg_left = $urandom_range(1, 60);
        mode = $urandom_range(0, 3);
        phase = 0;
      end
      seg_left--;
      phase++;
      case (mode)
        0: pop_next = 1'b1;
        1: pop_next = 1'($urandom_range(0, 1));
        2: pop_next = (phase % 3) == 0;
        default: pop_next = $urandom_range(0, 3) == 0;
      endcase
      if (hold_left > 0) begin
        pop_next = 1'b0;
        hold_left--;
      end
      pop <= pop_next;
    end
  end

  initial begin : stimulus
    in_word_t w;
    rst_n = 1'b0;
    push = 1'b0;
    in_word = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      w.operation = directed_rows[i].op;
      w.operand_a = directed_rows[i].a;
      w.operand_b = directed_rows[i].b;
      offer(w, directed_rows[i].pinned, directed_rows[i].want);
    end
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      offer(random_word(), 1'b0, '0);
    end
    push <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d results from %0d words: %0d multiply, %0d divide, %0d unused codes.",
             results_checked, words_accepted, mul_words, div_words, unused_words);
    $display("%0d divides by zero, %0d clamped results, longest input stall %0d cycles.",
             zero_div_results, clamped_results, longest_full_stall);
    if (error_count == 0) begin
      $display("** fixed_point_q24_8_alu: PASSED **");
    end else begin
      $display("** fixed_point_q24_8_alu: FAILED **");
    end
    $finish;
  end

  initial begin : watchdog
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles, %0d results still expected.",
             cycle_count, expected_results.size());
    $display("** fixed_point_q24_8_alu: FAILED **");
    $finish;
  end

endmodule
